// ===== rtl/pmsb_pkg.sv =====
package pmsb_pkg;

   localparam int PIX_W = 8;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_START = 2'd1,
      MODE_DATA  = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WR0,
      ST_WR1,
      ST_CLEAR
   } state_type;

endpackage

// ===== rtl/page_mode_sprite_blitter.sv =====
// Monochrome page-mode frame store with sprite blit.
// Command channel: a beat is taken when start is high and busy is low;
// req_mode selects clear, sprite start, sprite data byte or read.
// Result channel: rsp_valid marks a one-cycle beat carrying a frame store
// byte with its page, column and last flag; the receiver cannot stall it.
// Sequencing per mode:
//   start  - no result; the block stays idle.
//   read   - result appears the cycle after the beat is taken.
//   data   - ST_WR0 then ST_WR1 when the shifted byte spills onto a
//            visible lower page (read-modify-write of two store words
//            via the single write port), else ST_WR0; idle if ignored.
//   clear  - ST_CLEAR zeroes all SCREEN_COLUMNS * SCREEN_PAGES words,
//            one store word written per cycle after the beat.
// Reset: synchronous; afterwards the block runs the same clearing sweep
// with busy high before taking its first beat.
// Read order is page-major and wraps to the first byte after the last.
module page_mode_sprite_blitter
   import pmsb_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 84,
   parameter int SCREEN_PAGES   = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [7:0]         req_sprite_width,
   input  logic [7:0]         req_sprite_height,
   input  logic               req_invert,
   input  logic [7:0]         req_sprite_byte,
   output logic               rsp_valid,
   output logic [7:0]         rsp_pixel_byte,
   output logic [2:0]         rsp_out_page,
   output logic [6:0]         rsp_out_column,
   output logic               rsp_frame_last
);

   localparam int STORE_SIZE = SCREEN_COLUMNS * SCREEN_PAGES;
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [PIX_W-1:0]  mem_wdata, mem_rdata;

   pmsb_ctrl #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_PAGES   (SCREEN_PAGES),
      .ADDR_W         (ADDR_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_sprite_width  (req_sprite_width),
      .req_sprite_height (req_sprite_height),
      .req_invert        (req_invert),
      .req_sprite_byte   (req_sprite_byte),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .mem_raddr         (mem_raddr),
      .mem_rdata         (mem_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_out_page      (rsp_out_page),
      .rsp_out_column    (rsp_out_column),
      .rsp_frame_last    (rsp_frame_last)
   );

   pmsb_store #(
      .DEPTH  (STORE_SIZE),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rsp_pixel_byte = mem_rdata;

endmodule

// ===== rtl/pmsb_store.sv =====
module pmsb_store
   import pmsb_pkg::*;
#(
   parameter int DEPTH  = 504,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [PIX_W-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [PIX_W-1:0]  rdata
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pmsb_ctrl.sv =====
module pmsb_ctrl
   import pmsb_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 84,
   parameter int SCREEN_PAGES   = 6,
   parameter int ADDR_W         = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [7:0]        req_sprite_width,
   input  logic [7:0]        req_sprite_height,
   input  logic              req_invert,
   input  logic [7:0]        req_sprite_byte,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [PIX_W-1:0]  mem_wdata,
   output logic [ADDR_W-1:0] mem_raddr,
   input  logic [PIX_W-1:0]  mem_rdata,
   output logic              rsp_valid,
   output logic [2:0]        rsp_out_page,
   output logic [6:0]        rsp_out_column,
   output logic              rsp_frame_last
);

   localparam int STORE_SIZE = SCREEN_COLUMNS * SCREEN_PAGES;
   localparam int PAGE_W     = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
   localparam int COL_W      = $clog2(SCREEN_COLUMNS);

   state_type state_ff, state_in;

   logic signed [15:0] origin_x_ff, origin_y_ff;
   logic [7:0]         width_ff;
   logic [4:0]         pages_ff;
   logic               invert_ff;
   logic [7:0]         cur_col_ff;
   logic [4:0]         cur_page_ff;

   logic [PAGE_W-1:0]  rd_page_ff;
   logic [COL_W-1:0]   rd_col_ff;
   logic [ADDR_W-1:0]  clr_ff;

   logic [ADDR_W-1:0]  addr0_ff, addr1_ff;
   logic [PIX_W-1:0]   bits0_ff, bits1_ff;
   logic               wr0_en_ff, wr1_en_ff;

   logic               rsp_valid_ff, rsp_last_ff;
   logic [2:0]         rsp_page_ff;
   logic [6:0]         rsp_col_ff;

   logic               accept;
   logic [16:0]        col_sum;
   logic [13:0]        page0_sum, page1_sum;
   logic               col_ok, pg0_ok, pg1_ok, blit_ok;
   logic [2:0]         shift;
   logic [PIX_W-1:0]   pix;
   logic [15:0]        pix_wide;
   logic [ADDR_W-1:0]  addr0, addr1, rd_addr;
   logic               rd_last;
   logic [8:0]         col_next;
   logic [4:0]         h_pages;

   assign accept = start && (state_ff == ST_IDLE);

   assign col_sum   = {origin_x_ff[15], origin_x_ff} + {9'd0, cur_col_ff};
   assign page0_sum = {{1{origin_y_ff[15]}}, origin_y_ff[15:3]} + {9'd0, cur_page_ff};
   assign page1_sum = page0_sum + 14'd1;
   assign col_ok    = !col_sum[16] && (col_sum[15:0] < 16'(SCREEN_COLUMNS));
   assign pg0_ok    = !page0_sum[13] && (page0_sum[12:0] < 13'(SCREEN_PAGES));
   assign pg1_ok    = !page1_sum[13] && (page1_sum[12:0] < 13'(SCREEN_PAGES));
   assign blit_ok   = (width_ff != 8'd0) && (cur_page_ff < pages_ff);
   assign shift     = origin_y_ff[2:0];
   assign pix       = invert_ff ? ~req_sprite_byte : req_sprite_byte;
   assign pix_wide  = {8'd0, pix} << shift;

   assign addr0 = ADDR_W'(page0_sum[PAGE_W-1:0] * SCREEN_COLUMNS)
                + ADDR_W'(col_sum[COL_W-1:0]);
   assign addr1 = ADDR_W'(page1_sum[PAGE_W-1:0] * SCREEN_COLUMNS)
                + ADDR_W'(col_sum[COL_W-1:0]);
   assign rd_addr = ADDR_W'(rd_page_ff * SCREEN_COLUMNS) + ADDR_W'(rd_col_ff);
   assign rd_last = (rd_page_ff == PAGE_W'(SCREEN_PAGES - 1))
                 && (rd_col_ff == COL_W'(SCREEN_COLUMNS - 1));

   assign col_next = {1'b0, cur_col_ff} + 9'd1;
   assign h_pages  = (req_sprite_height[7:3] == 5'd0) ? 5'd1 : req_sprite_height[7:3];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_CLEAR) begin
               state_in = ST_CLEAR;
            end else if (accept && req_mode == MODE_DATA && blit_ok) begin
               state_in = ST_WR0;
            end
         end
         ST_WR0:   state_in = wr1_en_ff ? ST_WR1 : ST_IDLE;
         ST_WR1:   state_in = ST_IDLE;
         ST_CLEAR: state_in = (clr_ff == ADDR_W'(STORE_SIZE - 1)) ? ST_IDLE : ST_CLEAR;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr0_ff;
      mem_wdata = mem_rdata | bits0_ff;
      mem_raddr = addr0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_mode == MODE_READ) begin
               mem_raddr = rd_addr;
            end
         end
         ST_WR0: begin
            mem_we    = wr0_en_ff;
            mem_raddr = addr1_ff;
         end
         ST_WR1: begin
            mem_we    = 1'b1;
            mem_waddr = addr1_ff;
            mem_wdata = mem_rdata | bits1_ff;
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         width_ff     <= '0;
         pages_ff     <= 5'd1;
         invert_ff    <= 1'b0;
         cur_col_ff   <= '0;
         cur_page_ff  <= '0;
         rd_page_ff   <= '0;
         rd_col_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         wr0_en_ff    <= 1'b0;
         wr1_en_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= accept && req_mode == MODE_READ;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (accept) begin
            case (req_mode)
               MODE_CLEAR: begin
                  clr_ff     <= '0;
                  rd_page_ff <= '0;
                  rd_col_ff  <= '0;
               end
               MODE_START: begin
                  origin_x_ff <= req_pos_x;
                  origin_y_ff <= req_pos_y;
                  width_ff    <= req_sprite_width;
                  pages_ff    <= h_pages;
                  invert_ff   <= req_invert;
                  cur_col_ff  <= '0;
                  cur_page_ff <= '0;
               end
               MODE_DATA: begin
                  if (blit_ok) begin
                     wr0_en_ff <= col_ok && pg0_ok;
                     wr1_en_ff <= col_ok && pg1_ok && (shift != 3'd0);
                     if (col_next >= {1'b0, width_ff}) begin
                        cur_col_ff  <= '0;
                        cur_page_ff <= cur_page_ff + 5'd1;
                     end else begin
                        cur_col_ff <= col_next[7:0];
                     end
                  end
               end
               default: begin
                  if (rd_last) begin
                     rd_page_ff <= '0;
                     rd_col_ff  <= '0;
                  end else if (rd_col_ff == COL_W'(SCREEN_COLUMNS - 1)) begin
                     rd_col_ff  <= '0;
                     rd_page_ff <= rd_page_ff + PAGE_W'(1);
                  end else begin
                     rd_col_ff <= rd_col_ff + COL_W'(1);
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr0_ff    <= addr0;
         addr1_ff    <= addr1;
         bits0_ff    <= pix_wide[7:0];
         bits1_ff    <= pix_wide[15:8];
         rsp_page_ff <= 3'(rd_page_ff);
         rsp_col_ff  <= 7'(rd_col_ff);
         rsp_last_ff <= rd_last;
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_page   = rsp_page_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_frame_last = rsp_last_ff;

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept && req_mode == MODE_READ))
      else $error("response without read beat");

   a_wr1_after_wr0: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR1) |-> $past(state_ff == ST_WR0))
      else $error("second page write out of order");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cur_page_ff <= pages_ff)
      else $error("sprite cursor overran page count");

   a_clear_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (clr_ff < ADDR_W'(STORE_SIZE)))
      else $error("clear sweep beyond store");

endmodule
